[rtl/icy_metadata_deframer_macros.svh]
// assertion macros shared by the deframer rtl
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef ICY_METADATA_DEFRAMER_MACROS_SVH
`define ICY_METADATA_DEFRAMER_MACROS_SVH

// condition implies consequence in the same cycle
`define ICYMD_ASSERT_NOW(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error("deframer check failed");

// condition implies consequence in the next cycle
`define ICYMD_ASSERT_NEXT(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error("deframer check failed");

`endif

[rtl/icymd_pkg.sv]
// shared types, constants and the key table of the icy metadata deframer
// no dependencies
package icymd_pkg;

	localparam int TITLE_MAX  = 127;
	localparam int INTERVAL_W = 16;
	localparam int META_CW    = 12;
	localparam int KEY_LEN    = 13;
	localparam int KEY_CW     = 4;
	localparam int QDEPTH     = 4;
	localparam int QCW        = $clog2(QDEPTH + 1);

	localparam logic [7:0] CHAR_QUOTE = 8'h27;
	localparam logic [7:0] CHAR_NUL   = 8'h00;

	typedef enum logic [1:0] {
		KIND_AUDIO  = 2'd0,
		KIND_CHAR   = 2'd1,
		KIND_COMMIT = 2'd2,
		KIND_ABORT  = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		logic           full;
		logic           empty;
		logic [QCW-1:0] count;
	} q_status_t;

	typedef struct packed {
		logic in_meta;
		logic in_title;
		logic finished;
	} front_status_t;

	// characters of StreamTitle='
	function automatic logic [7:0] key_char(input logic [KEY_CW-1:0] pos);
		logic [7:0] c;
		case (pos)
			4'd0:    c = "S";
			4'd1:    c = "t";
			4'd2:    c = "r";
			4'd3:    c = "e";
			4'd4:    c = "a";
			4'd5:    c = "m";
			4'd6:    c = "T";
			4'd7:    c = "i";
			4'd8:    c = "t";
			4'd9:    c = "l";
			4'd10:   c = "e";
			4'd11:   c = "=";
			4'd12:   c = CHAR_QUOTE;
			default: c = CHAR_NUL;
		endcase
		return c;
	endfunction

endpackage

[rtl/icy_metadata_deframer.sv]
// channel   | handshake           | payload
// input     | push / full         | stream_byte[7:0]
// result    | empty / pop         | kind[1:0], out_byte[7:0]
// config    | cfg_valid/cfg_ready | cfg_data[15:0] (meta_interval)
//
// One byte is taken every cycle while full is low; the front end works out its
// counters and key match combinationally and writes at most one item into a
// four-entry queue; items move on to the output register when free or popped.
// full follows the queue fill alone, so the input stalls only when the
// consumer has left four items plus the output register untaken.
// Asynchronous active-low reset; no clearing pass, the block is ready at once.
// top level of the icy metadata deframer, depends on icymd_pkg, the front end,
// queue and output stage modules, and the assertion macro header
`include "icy_metadata_deframer_macros.svh"

module icy_metadata_deframer #(
	parameter int TITLE_MAX = icymd_pkg::TITLE_MAX
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [7:0]                       stream_byte,
	output logic                             empty,
	input  logic                             pop,
	output logic [1:0]                       kind,
	output logic [7:0]                       out_byte,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [icymd_pkg::INTERVAL_W-1:0] cfg_data
);

	logic                      in_accept;
	logic                      res_valid;
	icymd_pkg::item_t          res_item;
	icymd_pkg::front_status_t  front_st;
	icymd_pkg::q_status_t      q_st;
	icymd_pkg::item_t          q_item;
	logic                      q_rd;

	assign cfg_ready = 1'b1;
	assign full      = q_st.full;
	assign in_accept = push && !q_st.full;

	// classify bytes and track framing
	icymd_front #(
		.TITLE_MAX (TITLE_MAX)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_accept),
		.in_byte   (stream_byte),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.res_valid (res_valid),
		.res_item  (res_item),
		.status    (front_st)
	);

	// decoupling queue
	icymd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (in_accept && res_valid),
		.wr_item (res_item),
		.rd_en   (q_rd),
		.rd_item (q_item),
		.status  (q_st)
	);

	// output register
	icymd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_st.empty),
		.q_item   (q_item),
		.q_rd     (q_rd),
		.pop      (pop),
		.empty    (empty),
		.kind     (kind),
		.out_byte (out_byte)
	);

	// checks
	`ICYMD_ASSERT_NOW(a_q_bound, 1'b1, q_st.count <= icymd_pkg::QCW'(icymd_pkg::QDEPTH))
	`ICYMD_ASSERT_NOW(a_flags_excl, 1'b1, !(front_st.in_title && front_st.finished))
	`ICYMD_ASSERT_NOW(a_event_zero, !empty && (kind == icymd_pkg::KIND_COMMIT || kind == icymd_pkg::KIND_ABORT), out_byte == 8'h00)
	`ICYMD_ASSERT_NEXT(a_cfg_audio, cfg_valid && cfg_ready, !front_st.in_meta && !front_st.in_title)

endmodule

[rtl/icymd_front.sv]
// front end: takes stream bytes, tracks audio/length/metadata framing and title matching
// depends on icymd_pkg
module icymd_front #(
	parameter int TITLE_MAX = icymd_pkg::TITLE_MAX
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic [7:0]                           in_byte,
	input  logic                                 cfg_wr,
	input  logic [icymd_pkg::INTERVAL_W-1:0]     cfg_data,
	output logic                                 res_valid,
	output icymd_pkg::item_t                     res_item,
	output icymd_pkg::front_status_t             status
);

	localparam int CW = $clog2(TITLE_MAX + 1);

	typedef enum logic [1:0] {
		PH_AUDIO = 2'd0,
		PH_LEN   = 2'd1,
		PH_META  = 2'd2
	} phase_t;

	phase_t                               phase_q, phase_d;
	logic [icymd_pkg::INTERVAL_W-1:0]     interval_q;
	logic [icymd_pkg::INTERVAL_W-1:0]     audio_left_q, audio_left_d;
	logic [icymd_pkg::META_CW-1:0]        meta_left_q, meta_left_d;
	logic [icymd_pkg::KEY_CW-1:0]         match_pos_q, match_pos_d;
	logic [CW-1:0]                        title_count_q, title_count_d;
	logic                                 in_title_q, in_title_d;
	logic                                 finished_q, finished_d;
	logic                                 last;

	// next state and result for one accepted byte
	always_comb begin
		phase_d       = phase_q;
		audio_left_d  = audio_left_q;
		meta_left_d   = meta_left_q;
		match_pos_d   = match_pos_q;
		title_count_d = title_count_q;
		in_title_d    = in_title_q;
		finished_d    = finished_q;
		res_valid     = 1'b0;
		res_item.kind = icymd_pkg::KIND_AUDIO;
		res_item.data = in_byte;
		last          = (meta_left_q <= icymd_pkg::META_CW'(1));
		case (phase_q)
			PH_LEN: begin
				match_pos_d   = '0;
				title_count_d = '0;
				in_title_d    = 1'b0;
				finished_d    = 1'b0;
				if (in_byte == icymd_pkg::CHAR_NUL) begin
					meta_left_d  = '0;
					phase_d      = PH_AUDIO;
					audio_left_d = interval_q;
				end else begin
					meta_left_d = {in_byte, 4'b0000};
					phase_d     = PH_META;
				end
			end
			PH_META: begin
				meta_left_d   = last ? '0 : meta_left_q - icymd_pkg::META_CW'(1);
				res_item.data = icymd_pkg::CHAR_NUL;
				if (!finished_q) begin
					if (in_title_q) begin
						if (in_byte == icymd_pkg::CHAR_QUOTE) begin
							res_valid     = 1'b1;
							res_item.kind = icymd_pkg::KIND_COMMIT;
							in_title_d    = 1'b0;
							finished_d    = 1'b1;
						end else if (in_byte == icymd_pkg::CHAR_NUL) begin
							res_valid     = 1'b1;
							res_item.kind = icymd_pkg::KIND_ABORT;
							in_title_d    = 1'b0;
							finished_d    = 1'b1;
						end else if (title_count_q < CW'(TITLE_MAX)) begin
							res_valid     = 1'b1;
							res_item.kind = icymd_pkg::KIND_CHAR;
							res_item.data = in_byte;
							title_count_d = title_count_q + CW'(1);
						end
					end else if (in_byte == icymd_pkg::CHAR_NUL) begin
						finished_d = 1'b1;
					end else begin
						// keyword match, restart on the first key character
						if (match_pos_q < icymd_pkg::KEY_CW'(icymd_pkg::KEY_LEN) &&
						    in_byte == icymd_pkg::key_char(match_pos_q))
							match_pos_d = match_pos_q + icymd_pkg::KEY_CW'(1);
						else if (in_byte == icymd_pkg::key_char('0))
							match_pos_d = icymd_pkg::KEY_CW'(1);
						else
							match_pos_d = '0;
						if (match_pos_d >= icymd_pkg::KEY_CW'(icymd_pkg::KEY_LEN))
							in_title_d = 1'b1;
					end
				end
				// block end: an open title is aborted
				if (last) begin
					if (in_title_d && !finished_d) begin
						res_valid     = 1'b1;
						res_item.kind = icymd_pkg::KIND_ABORT;
						res_item.data = icymd_pkg::CHAR_NUL;
					end
					phase_d       = PH_AUDIO;
					audio_left_d  = interval_q;
					meta_left_d   = '0;
					match_pos_d   = '0;
					title_count_d = '0;
					in_title_d    = 1'b0;
					finished_d    = 1'b0;
				end
			end
			default: begin
				phase_d   = PH_AUDIO;
				res_valid = 1'b1;
				if (interval_q != '0) begin
					if (audio_left_q <= icymd_pkg::INTERVAL_W'(1)) begin
						audio_left_d = '0;
						phase_d      = PH_LEN;
					end else begin
						audio_left_d = audio_left_q - icymd_pkg::INTERVAL_W'(1);
					end
				end
			end
		endcase
	end

	// state registers, config write reloads and drops any block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_AUDIO;
			interval_q    <= '0;
			audio_left_q  <= '0;
			meta_left_q   <= '0;
			match_pos_q   <= '0;
			title_count_q <= '0;
			in_title_q    <= 1'b0;
			finished_q    <= 1'b0;
		end else if (cfg_wr) begin
			phase_q       <= PH_AUDIO;
			interval_q    <= cfg_data;
			audio_left_q  <= cfg_data;
			meta_left_q   <= '0;
			match_pos_q   <= '0;
			title_count_q <= '0;
			in_title_q    <= 1'b0;
			finished_q    <= 1'b0;
		end else if (in_valid) begin
			phase_q       <= phase_d;
			audio_left_q  <= audio_left_d;
			meta_left_q   <= meta_left_d;
			match_pos_q   <= match_pos_d;
			title_count_q <= title_count_d;
			in_title_q    <= in_title_d;
			finished_q    <= finished_d;
		end
	end

	assign status.in_meta  = (phase_q == PH_META);
	assign status.in_title = in_title_q;
	assign status.finished = finished_q;

endmodule

[rtl/icymd_queue.sv]
// short result queue between the front end and the output stage
// depends on icymd_pkg
module icymd_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  icymd_pkg::item_t       wr_item,
	input  logic                   rd_en,
	output icymd_pkg::item_t       rd_item,
	output icymd_pkg::q_status_t   status
);

	localparam int PW = $clog2(icymd_pkg::QDEPTH);

	icymd_pkg::item_t            mem_q [icymd_pkg::QDEPTH];
	logic [PW-1:0]               wr_ptr_q;
	logic [PW-1:0]               rd_ptr_q;
	logic [icymd_pkg::QCW-1:0]   count_q;
	logic                        do_wr;
	logic                        do_rd;

	assign status.full  = (count_q == icymd_pkg::QCW'(icymd_pkg::QDEPTH));
	assign status.empty = (count_q == '0);
	assign status.count = count_q;
	assign do_wr        = wr_en && !status.full;
	assign do_rd        = rd_en && !status.empty;
	assign rd_item      = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_item;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= wr_ptr_q + PW'(1);
			if (do_rd)
				rd_ptr_q <= rd_ptr_q + PW'(1);
			if (do_wr && !do_rd)
				count_q <= count_q + icymd_pkg::QCW'(1);
			else if (do_rd && !do_wr)
				count_q <= count_q - icymd_pkg::QCW'(1);
		end
	end

endmodule

[rtl/icymd_back.sv]
// output stage: holds the oldest result item for the consumer
// depends on icymd_pkg
module icymd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  icymd_pkg::item_t   q_item,
	output logic               q_rd,
	input  logic               pop,
	output logic               empty,
	output logic [1:0]         kind,
	output logic [7:0]         out_byte
);

	logic             valid_q;
	icymd_pkg::item_t item_q;

	// refill when the stage is free or being drained
	assign q_rd     = !q_empty && (!valid_q || pop);
	assign empty    = !valid_q;
	assign kind     = item_q.kind;
	assign out_byte = item_q.data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_rd) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd)
			item_q <= q_item;
	end

endmodule
